// File: rtl/core/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants of the line segment rasterizer
// Command codes, minor-axis direction codes, register map and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

  // Default widths of coordinates and color
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS_DEF = 24;

  // Canvas size registers
  localparam int unsigned CFG_BITS = 12;
  localparam logic [CFG_BITS-1:0] CANVAS_RESET = 12'd1024;

  // Register port
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned REG_IDX_BIT = 2;
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  // Command codes of an input word
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Depth of the queue between the setup and the stepper
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } lsr_dir_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] canvas_width;
    logic [CFG_BITS-1:0] canvas_height;
  } lsr_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/lsr_if.sv
// ----------------------------------------------------------------------------
// lsr_if: ready/valid channels of the line segment rasterizer
// Command channel (start and step words) and pixel channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsr_cmd_if #(
  parameter int unsigned COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lsr_pkg::COLOR_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0]        color_in;

  modport source (
    output valid, cmd, x_start, y_start, x_end, y_end, color_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_start, y_start, x_end, y_end, color_in,
    output ready
  );
endinterface

interface lsr_pix_if #(
  parameter int unsigned COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lsr_pkg::COLOR_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]        color_out;
  logic                         inside_res;
  logic                         last;

  modport source (
    output valid, pixel_x, pixel_y, color_out, inside_res, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, color_out, inside_res, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/lsr_front.sv
// ----------------------------------------------------------------------------
// lsr_front: command intake and segment setup
// Registers each command word with its endpoint deltas, then forms the
// major axis, endpoint order, deltas and initial error for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_front #(
  parameter int unsigned COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lsr_pkg::COLOR_BITS_DEF,
  parameter type         entry_t    = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lsr_cmd_if.sink   cmd_i,
  input  wire logic full_i,
  output logic      push_o,
  output entry_t    entry_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned EW = COORD_BITS + 3;

  logic                         accept;
  logic signed [DW-1:0]         dx_d, dy_d;
  logic [DW-1:0]                adx_d, ady_d;

  logic                         s1_valid_q;
  logic                         s1_cmd_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [DW-1:0]         dx_q, dy_q;
  logic [DW-1:0]                adx_q, ady_q;
  logic [COLOR_BITS-1:0]        color_q;

  logic                         x_major;
  logic                         swap;
  logic signed [DW-1:0]         da, db;
  logic signed [COORD_BITS-1:0] a1, a2, b1, b2;
  logic [DW-1:0]                maj_delta;
  logic signed [DW-1:0]         min_delta;
  logic signed [EW-1:0]         maj_ext, min_ext;
  logic                         min_pos, min_neg;

  assign cmd_i.ready = !s1_valid_q || !full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign push_o      = s1_valid_q && !full_i;

  assign dx_d  = DW'(cmd_i.x_end) - DW'(cmd_i.x_start);
  assign dy_d  = DW'(cmd_i.y_end) - DW'(cmd_i.y_start);
  assign adx_d = dx_d[DW-1] ? DW'(-dx_d) : DW'(dx_d);
  assign ady_d = dy_d[DW-1] ? DW'(-dy_d) : DW'(dy_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= cmd_i.cmd;
      x1_q     <= cmd_i.x_start;
      y1_q     <= cmd_i.y_start;
      x2_q     <= cmd_i.x_end;
      y2_q     <= cmd_i.y_end;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      color_q  <= cmd_i.color_in;
    end
  end

  // Ties go to the y axis
  assign x_major   = adx_q > ady_q;
  assign da        = x_major ? dx_q : dy_q;
  assign db        = x_major ? dy_q : dx_q;
  assign a1        = x_major ? x1_q : y1_q;
  assign a2        = x_major ? x2_q : y2_q;
  assign b1        = x_major ? y1_q : x1_q;
  assign b2        = x_major ? y2_q : x2_q;
  assign swap      = da[DW-1];
  assign maj_delta = x_major ? adx_q : ady_q;
  assign min_delta = swap ? -db : db;
  assign maj_ext   = signed'(EW'(maj_delta));
  assign min_ext   = EW'(min_delta);
  assign min_neg   = min_delta[DW-1];
  assign min_pos   = !min_delta[DW-1] && (min_delta != '0);

  always_comb begin
    entry_o             = '0;
    entry_o.is_start    = (s1_cmd_q == lsr_pkg::CMD_START);
    entry_o.x_major     = x_major;
    entry_o.major_pos   = swap ? a2 : a1;
    entry_o.major_end   = swap ? a1 : a2;
    entry_o.minor_pos   = swap ? b2 : b1;
    entry_o.major_delta = maj_delta;
    entry_o.minor_delta = min_delta;
    entry_o.error_term  = min_pos ? (min_ext - maj_ext) : (min_ext + maj_ext);
    entry_o.color       = color_q;
    if (min_pos) begin
      entry_o.minor_dir = lsr_pkg::DIR_UP;
    end else if (min_neg) begin
      entry_o.minor_dir = lsr_pkg::DIR_DOWN;
    end else begin
      entry_o.minor_dir = lsr_pkg::DIR_NONE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lsr_fifo.sv
// ----------------------------------------------------------------------------
// lsr_fifo: short queue between setup and stepper
// Circular buffer of setup words with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_fifo #(
  parameter int unsigned DEPTH   = lsr_pkg::QUEUE_DEPTH,
  parameter type         entry_t = logic
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output entry_t      entry_o,
  output logic        empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lsr_back.sv
// ----------------------------------------------------------------------------
// lsr_back: segment stepper and pixel output register
// Loads a segment on a start word and emits one pixel per step word while a
// segment is active, with the canvas-inside flag and the final-pixel flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_back #(
  parameter int unsigned COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lsr_pkg::COLOR_BITS_DEF,
  parameter type         entry_t    = logic
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      empty_i,
  input  wire entry_t    entry_i,
  output logic           pop_o,
  input  wire lsr_pkg::lsr_cfg_t cfg_i,
  lsr_pix_if.source      pix_o
);

  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned EW    = COORD_BITS + 3;
  localparam int unsigned CMP_W = (COORD_BITS > lsr_pkg::CFG_BITS) ?
                                  COORD_BITS : lsr_pkg::CFG_BITS;

  logic                         active_q;
  logic                         x_major_q;
  logic signed [COORD_BITS-1:0] major_pos_q, major_end_q, minor_pos_q;
  lsr_pkg::lsr_dir_e            minor_dir_q;
  logic [DW-1:0]                major_delta_q;
  logic signed [DW-1:0]         minor_delta_q;
  logic signed [EW-1:0]         error_q;
  logic [COLOR_BITS-1:0]        color_q;

  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [COLOR_BITS-1:0]        out_color_q;
  logic                         inside_q, last_q;

  logic                         can_emit, load, emit;
  logic signed [COORD_BITS-1:0] px, py;
  logic [CMP_W-1:0]             px_ext, py_ext;
  logic                         in_canvas, fin;
  logic                         move_up, move_dn;
  logic signed [EW-1:0]         maj_ext, adj, error_d;
  logic signed [COORD_BITS-1:0] minor_d;

  assign can_emit = !out_valid_q || pix_o.ready;
  // Steps while idle drain without a pixel
  assign pop_o = !empty_i && (entry_i.is_start || !active_q || can_emit);
  assign load  = pop_o && entry_i.is_start;
  assign emit  = pop_o && !entry_i.is_start && active_q;

  assign px     = x_major_q ? major_pos_q : minor_pos_q;
  assign py     = x_major_q ? minor_pos_q : major_pos_q;
  assign px_ext = CMP_W'(px);
  assign py_ext = CMP_W'(py);
  assign in_canvas = !px[COORD_BITS-1] && (px_ext < CMP_W'(cfg_i.canvas_width)) &&
                     !py[COORD_BITS-1] && (py_ext < CMP_W'(cfg_i.canvas_height));
  assign fin    = major_pos_q >= major_end_q;

  assign move_up = !error_q[EW-1] && (error_q != '0) && (minor_dir_q == lsr_pkg::DIR_UP);
  assign move_dn = error_q[EW-1] && (minor_dir_q == lsr_pkg::DIR_DOWN);
  assign maj_ext = signed'(EW'(major_delta_q));
  assign adj     = move_up ? -maj_ext : (move_dn ? maj_ext : '0);
  assign error_d = error_q + EW'(minor_delta_q) + adj;
  assign minor_d = move_up ? minor_pos_q + COORD_BITS'(1) :
                   (move_dn ? minor_pos_q - COORD_BITS'(1) : minor_pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      x_major_q     <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      minor_dir_q   <= lsr_pkg::DIR_NONE;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      error_q       <= '0;
      color_q       <= '0;
    end else if (load) begin
      active_q      <= 1'b1;
      x_major_q     <= entry_i.x_major;
      major_pos_q   <= entry_i.major_pos;
      major_end_q   <= entry_i.major_end;
      minor_pos_q   <= entry_i.minor_pos;
      minor_dir_q   <= entry_i.minor_dir;
      major_delta_q <= entry_i.major_delta;
      minor_delta_q <= entry_i.minor_delta;
      error_q       <= entry_i.error_term;
      color_q       <= entry_i.color;
    end else if (emit) begin
      minor_pos_q <= minor_d;
      error_q     <= error_d;
      if (fin) begin
        active_q <= 1'b0;
      end else begin
        major_pos_q <= major_pos_q + COORD_BITS'(1);
      end
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q        <= px;
      py_q        <= py;
      out_color_q <= color_q;
      inside_q    <= in_canvas;
      last_q      <= fin;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_x    = px_q;
  assign pix_o.pixel_y    = py_q;
  assign pix_o.color_out  = out_color_q;
  assign pix_o.inside_res = inside_q;
  assign pix_o.last       = last_q;

endmodule

`default_nettype wire

// File: rtl/core/line_segment_rasterizer_core.sv
// ----------------------------------------------------------------------------
// line_segment_rasterizer_core: Bresenham line segment rasterizer
// Setup front end, command queue and pixel stepper with a register port
// for the canvas size.
// ----------------------------------------------------------------------------
// A start word (cmd 0) loads two endpoints and a color and yields no pixel; each
// following step word (cmd 1) yields one pixel, the last one flagged, and steps
// arriving with no segment running are dropped. Words are taken one per clock
// while the queue has room and pixels leave one per clock while the pixel port
// is ready: the stepper updates position and error term on each step word, and
// a start word takes one queue slot. A pixel passes the intake register, the
// queue and the output register before it is presented. A four-word queue lets
// the intake run while the pixel port stalls. Canvas width and height sit at
// byte addresses 0 and 4 and reset to 1024; write them only while idle.
`default_nettype none

module line_segment_rasterizer_core #(
  parameter int unsigned COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lsr_pkg::COLOR_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  lsr_cmd_if.sink                                 cmd_i,
  lsr_pix_if.source                               pix_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lsr_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [lsr_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lsr_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                    pready
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned EW = COORD_BITS + 3;

  typedef struct packed {
    logic                         is_start;
    logic                         x_major;
    logic signed [COORD_BITS-1:0] major_pos;
    logic signed [COORD_BITS-1:0] major_end;
    logic signed [COORD_BITS-1:0] minor_pos;
    lsr_pkg::lsr_dir_e            minor_dir;
    logic [DW-1:0]                major_delta;
    logic signed [DW-1:0]         minor_delta;
    logic signed [EW-1:0]         error_term;
    logic [COLOR_BITS-1:0]        color;
  } entry_t;

  entry_t            push_entry, pop_entry;
  logic              push, pop, full, empty;
  logic              cfg_wr;
  lsr_pkg::lsr_cfg_t cfg_q;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width  <= lsr_pkg::CANVAS_RESET;
      cfg_q.canvas_height <= lsr_pkg::CANVAS_RESET;
    end else if (cfg_wr) begin
      if (paddr[lsr_pkg::REG_IDX_BIT] == lsr_pkg::REG_CANVAS_WIDTH) begin
        cfg_q.canvas_width <= pwdata[lsr_pkg::CFG_BITS-1:0];
      end else begin
        cfg_q.canvas_height <= pwdata[lsr_pkg::CFG_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[lsr_pkg::REG_IDX_BIT] == lsr_pkg::REG_CANVAS_HEIGHT) ?
                  lsr_pkg::APB_DATA_BITS'(cfg_q.canvas_height) :
                  lsr_pkg::APB_DATA_BITS'(cfg_q.canvas_width);

  lsr_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .entry_t    (entry_t)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  lsr_fifo #(
    .DEPTH   (lsr_pkg::QUEUE_DEPTH),
    .entry_t (entry_t)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  lsr_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .entry_t    (entry_t)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .cfg_i   (cfg_q),
    .pix_o   (pix_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/lsr_checker.sv
// ----------------------------------------------------------------------------
// lsr_checker: port-level checks of the line segment rasterizer
// Pixel channel behavior, clipping flag and canvas register readback.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_checker #(
  parameter int unsigned COORD_BITS = lsr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = lsr_pkg::COLOR_BITS_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [COORD_BITS-1:0]             pixel_x_i,
  input wire logic [COORD_BITS-1:0]             pixel_y_i,
  input wire logic [COLOR_BITS-1:0]             color_out_i,
  input wire logic                              inside_res_i,
  input wire logic                              last_i,
  input wire logic                              psel_i,
  input wire logic                              penable_i,
  input wire logic                              pwrite_i,
  input wire logic                              pready_i,
  input wire logic [lsr_pkg::APB_ADDR_BITS-1:0] paddr_i,
  input wire logic [lsr_pkg::APB_DATA_BITS-1:0] pwdata_i,
  input wire logic [lsr_pkg::APB_DATA_BITS-1:0] prdata_i
);

  // A stalled pixel holds
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_i && !out_ready_i) |=>
        (out_valid_i && $stable(pixel_x_i) && $stable(pixel_y_i) &&
         $stable(color_out_i) && $stable(inside_res_i) && $stable(last_i));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("pixel changed while stalled");

  // A pixel flagged inside never has a negative coordinate
  property p_inside_nonneg;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_i && inside_res_i) |->
        (!pixel_x_i[COORD_BITS-1] && !pixel_y_i[COORD_BITS-1]);
  endproperty
  a_inside_nonneg: assert property (p_inside_nonneg)
    else $error("inside flag on negative coordinate");

  // Nothing comes out right after reset
  property p_quiet_after_reset;
    @(posedge clk_i) disable iff (!rst_ni)
      !$past(rst_ni, 2) |-> !out_valid_i;
  endproperty
  a_quiet_after_reset: assert property (p_quiet_after_reset)
    else $error("pixel right after reset");

  // A canvas write reads back on the next cycle
  property p_cfg_readback;
    @(posedge clk_i) disable iff (!rst_ni)
      (psel_i && penable_i && pwrite_i && pready_i) ##1
        (paddr_i[lsr_pkg::REG_IDX_BIT] == $past(paddr_i[lsr_pkg::REG_IDX_BIT])) |->
        (prdata_i[lsr_pkg::CFG_BITS-1:0] == $past(pwdata_i[lsr_pkg::CFG_BITS-1:0]));
  endproperty
  a_cfg_readback: assert property (p_cfg_readback) else $error("canvas readback mismatch");

endmodule

bind line_segment_rasterizer_core lsr_checker #(
  .COORD_BITS (COORD_BITS),
  .COLOR_BITS (COLOR_BITS)
) u_lsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (pix_o.valid),
  .out_ready_i  (pix_o.ready),
  .pixel_x_i    (pix_o.pixel_x),
  .pixel_y_i    (pix_o.pixel_y),
  .color_out_i  (pix_o.color_out),
  .inside_res_i (pix_o.inside_res),
  .last_i       (pix_o.last),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .pready_i     (pready),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);

`default_nettype wire
